>>> sv/bwsd_pkg.sv
// ============================================================================
// bwsd_pkg - shared types and codes for the work-stealing deque
// Request and result layouts, operation and status codes, and the
// command/status structs that join the controller to the datapath.
// ============================================================================
package bwsd_pkg;

    // operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_STEAL = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] job_handle;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] taken_handle;
        logic [6:0]  occupancy;
    } t_out;

    // datapath actions issued by the controller
    typedef enum logic [3:0] {
        A_NONE,
        A_PUSH,
        A_FULL,
        A_EMPTY,
        A_OTHER,
        A_RD_POP,
        A_RD_STEAL,
        A_FIN_POP,
        A_FIN_STEAL
    } t_act;

    typedef struct packed {
        t_act act;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

>>> sv/bwsd_ctrl.sv
// ============================================================================
// bwsd_ctrl - request sequencer for the work-stealing deque
// Accepts a request, picks the datapath action, waits in S_READ for the
// store read on pop/steal, and owns the result valid flag.
// ============================================================================
module bwsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_operation,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  bwsd_pkg::t_dp_stat i_stat,
    output bwsd_pkg::t_cmd    o_cmd
);
    import bwsd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_pend_pop, n_pend_pop;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;
    t_act   act;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        act         = A_NONE;
        n_state     = r_state;
        n_pend_pop  = r_pend_pop;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    case (i_operation)
                        OP_PUSH: begin
                            act = i_stat.full ? A_FULL : A_PUSH;
                        end
                        OP_POP, OP_STEAL: begin
                            if (i_stat.empty) begin
                                act = A_EMPTY;
                            end else begin
                                act         = (i_operation == OP_POP) ? A_RD_POP : A_RD_STEAL;
                                n_pend_pop  = (i_operation == OP_POP);
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                            act = A_OTHER;
                        end
                    endcase
                end
            end
            S_READ: begin
                // output register was emptied when this request was taken
                act         = r_pend_pop ? A_FIN_POP : A_FIN_STEAL;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_pop  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_pop  <= n_pend_pop;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd.act   = act;

endmodule

>>> sv/bwsd_dp.sv
// ============================================================================
// bwsd_dp - handle store, top/bottom indices and result register
// Executes one controller action per cycle against the linear store.
// ============================================================================
module bwsd_dp #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_job_handle,
    input  bwsd_pkg::t_cmd     i_cmd,
    output bwsd_pkg::t_dp_stat o_stat,
    output bwsd_pkg::t_out     o_out_data
);
    import bwsd_pkg::*;

    localparam int IW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW = (IW > 7) ? IW : 7;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   r_rdata;
    logic [IW-1:0] r_top, n_top;
    logic [IW-1:0] r_bot, n_bot;
    t_out          r_out, n_out;
    logic          ld;
    logic [IW-1:0] bot_m1, bot_p1, top_p1;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    function automatic logic [6:0] occ_of(input logic [IW-1:0] b, input logic [IW-1:0] t);
        logic [DW-1:0] d;
        d = DW'(b) - DW'(t);
        return d[6:0];
    endfunction

    assign bot_m1 = r_bot - IW'(1);
    assign bot_p1 = r_bot + IW'(1);
    assign top_p1 = r_top + IW'(1);

    assign o_stat.full  = (r_bot == IW'(DEPTH));
    assign o_stat.empty = (r_bot == r_top);

    assign rd_addr = (i_cmd.act == A_RD_POP) ? bot_m1[AW-1:0] : r_top[AW-1:0];
    assign wr_en   = (i_cmd.act == A_PUSH);

    always_comb begin
        n_top = r_top;
        n_bot = r_bot;
        n_out = r_out;
        ld    = 1'b1;
        case (i_cmd.act)
            A_PUSH: begin
                n_bot = bot_p1;
                n_out = '{status: ST_DONE, taken_handle: 32'd0,
                          occupancy: occ_of(bot_p1, r_top)};
            end
            A_FULL: begin
                n_out = '{status: ST_FULL, taken_handle: 32'd0,
                          occupancy: occ_of(r_bot, r_top)};
            end
            A_EMPTY: begin
                n_out = '{status: ST_EMPTY, taken_handle: 32'd0,
                          occupancy: occ_of(r_bot, r_top)};
            end
            A_OTHER: begin
                n_out = '{status: ST_DONE, taken_handle: 32'd0,
                          occupancy: occ_of(r_bot, r_top)};
            end
            A_FIN_POP: begin
                if (r_rdata == 32'd0) begin
                    // zero handle: bottom stays moved down even on the last entry
                    n_bot = bot_m1;
                    n_out = '{status: ST_EMPTY, taken_handle: 32'd0,
                              occupancy: occ_of(bot_m1, r_top)};
                end else if (bot_m1 == r_top) begin
                    // last entry: top steps past it, bottom stays
                    n_top = r_bot;
                    n_out = '{status: ST_DONE, taken_handle: r_rdata, occupancy: 7'd0};
                end else begin
                    n_bot = bot_m1;
                    n_out = '{status: ST_DONE, taken_handle: r_rdata,
                              occupancy: occ_of(bot_m1, r_top)};
                end
            end
            A_FIN_STEAL: begin
                n_top = top_p1;
                n_out = '{status: ST_DONE, taken_handle: r_rdata,
                          occupancy: occ_of(r_bot, top_p1)};
            end
            default: begin
                ld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_bot[AW-1:0]] <= i_job_handle;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
            r_bot <= '0;
        end else begin
            r_top <= n_top;
            r_bot <= n_bot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> sv/bounded_work_stealing_deque_unit.sv
// ============================================================================
// bounded_work_stealing_deque_unit - bounded work-stealing deque
// Linear store of job handles between top and bottom; push and pop work
// at the bottom end, steal at the top end.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+-------------------
//   request | in        | i_in_valid / o_in_stall     | i_in_data  (t_in)
//   result  | out       | o_out_valid / i_out_stall   | o_out_data (t_out)
//
// Push, refused push, empty pop/steal and unknown codes: result in the
// cycle after the request. Pop/steal with entries: the controller waits
// in S_READ for the registered read port of the handle store.
// A new request is taken once idle and the result register is empty or being taken.
// Reset is synchronous and clears the indices; the store is not cleared.
// A stalled result holds and stalls the request side.
// ============================================================================
module bounded_work_stealing_deque_unit #(
    parameter int DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bwsd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bwsd_pkg::t_out o_out_data
);
    import bwsd_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    bwsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_data.operation),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bwsd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_handle (i_in_data.job_handle),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_data   (o_out_data)
    );

endmodule

>>> sv/bwsd_checker.sv
// ============================================================================
// bwsd_checker - port-level checks for the work-stealing deque
// Watches the top-level handshakes and result fields over time.
// ============================================================================
module bwsd_checker #(
    parameter int DEPTH = 64
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input bwsd_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input bwsd_pkg::t_out o_out_data
);
    import bwsd_pkg::*;

    // a held result blocks new requests
    a_hold_stalls_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request taken while result held");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_DONE || o_out_data.status == ST_FULL ||
                         o_out_data.status == ST_EMPTY))
        else $error("bad status code");

    a_no_handle_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_DONE) |-> (o_out_data.taken_handle == 32'd0))
        else $error("handle returned with failing status");

    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((DEPTH > 127) || (int'(o_out_data.occupancy) <= DEPTH)))
        else $error("occupancy above depth");

endmodule

bind bounded_work_stealing_deque_unit bwsd_checker #(.DEPTH(DEPTH)) u_bwsd_checker (.*);
